/* design/aarp_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// aarp_pkg
// Shared widths, constants, transaction types and helper functions for the
// point rotation core.
// ============================================================================
package aarp_pkg;

    localparam int TRIG_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES    = 24;
    localparam int XY_W            = 34;

    localparam logic signed [XY_W-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [XY_W-1:0] ONE_Q30      = 34'sd1073741824;
    localparam logic [32:0]            TWO_PI_Q46   = 33'd6746518852;

    typedef struct packed {
        logic [2:0][31:0] p;
        logic [2:0][31:0] o;
        logic [2:0][15:0] u;
        logic [5:0][31:0] uu;
        logic [1:0]       quad;
        logic             deg;
    } t_carry;

    typedef struct packed {
        logic [8:0][31:0] m;
        logic [2:0][31:0] p;
        logic [2:0][31:0] o;
        logic             deg;
    } t_mat;

    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [67:0] rnd68(input logic signed [67:0] v, input int n);
        logic signed [67:0] h;
        h = v >>> (n - 1);
        return (h + 68'sd1) >>> 1;
    endfunction

    function automatic logic [31:0] clamp_entry(input logic signed [39:0] v);
        logic [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'h7FFFFFFF;
        end else if (v < -40'sd2147483647) begin
            r = 32'h80000001;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* design/aarp_cordic_cell.sv */
`timescale 1ns / 1ps
// ============================================================================
// aarp_cordic_cell
// One rotation-mode CORDIC micro-rotation with a fixed shift, registered,
// passing the transaction payload to the next cell.
// ============================================================================
module aarp_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic signed [aarp_pkg::XY_W-1:0]   i_x,
    input  logic signed [aarp_pkg::XY_W-1:0]   i_y,
    input  logic signed [aarp_pkg::XY_W-1:0]   i_z,
    input  aarp_pkg::t_carry                   i_carry,
    output logic                               o_valid,
    output logic signed [aarp_pkg::XY_W-1:0]   o_x,
    output logic signed [aarp_pkg::XY_W-1:0]   o_y,
    output logic signed [aarp_pkg::XY_W-1:0]   o_z,
    output aarp_pkg::t_carry                   o_carry
);
    import aarp_pkg::*;

    localparam logic signed [XY_W-1:0] ATAN = $signed({2'b00, atan_q30(STAGE)});

    logic                   r_valid;
    logic signed [XY_W-1:0] r_x, r_y, r_z;
    logic signed [XY_W-1:0] n_x, n_y, n_z;
    t_carry                 r_carry;

    always_comb begin
        if (!i_z[XY_W-1]) begin
            n_x = i_x - (i_y >>> STAGE);
            n_y = i_y + (i_x >>> STAGE);
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + (i_y >>> STAGE);
            n_y = i_y - (i_x >>> STAGE);
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_carry <= i_carry;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_carry = r_carry;

endmodule

/* design/aarp_matrix.sv */
`timescale 1ns / 1ps
// ============================================================================
// aarp_matrix
// Quadrant correction of the CORDIC result and construction of the clamped
// Rodrigues matrix over three register stages.
// ============================================================================
module aarp_matrix (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [aarp_pkg::XY_W-1:0] i_x,
    input  logic signed [aarp_pkg::XY_W-1:0] i_y,
    input  aarp_pkg::t_carry                 i_carry,
    output logic                             o_valid,
    output aarp_pkg::t_mat                   o_mat
);
    import aarp_pkg::*;

    logic                   r_a_valid;
    logic signed [XY_W-1:0] r_a_c, r_a_s;
    logic signed [XY_W-1:0] n_a_c, n_a_s;
    t_carry                 r_a_carry;

    logic                   r_b_valid;
    logic signed [49:0]     r_b_lo [6];
    logic signed [48:0]     r_b_hi [6];
    logic signed [49:0]     r_b_us [3];
    logic signed [XY_W-1:0] r_b_c1;
    t_carry                 r_b_carry;
    logic signed [XY_W-1:0] n_b_t;

    logic                   r_c_valid;
    t_mat                   r_c_mat;
    logic signed [39:0]     n_c_r [6];
    logic signed [39:0]     n_c_s [3];
    logic signed [39:0]     n_c_c1;

    always_comb begin
        case (i_carry.quad)
            2'd0: begin
                n_a_c = i_x;
                n_a_s = i_y;
            end
            2'd1: begin
                n_a_c = -i_y;
                n_a_s = i_x;
            end
            2'd2: begin
                n_a_c = -i_x;
                n_a_s = -i_y;
            end
            default: begin
                n_a_c = i_y;
                n_a_s = -i_x;
            end
        endcase
    end

    assign n_b_t = ONE_Q30 - r_a_c;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_c_r[k] = 40'(rnd68(68'(r_b_hi[k]) * 68'sd131072 + 68'(r_b_lo[k]), 29));
        end
        for (int k = 0; k < 3; k++) begin
            n_c_s[k] = 40'(rnd68(68'(r_b_us[k]), 15));
        end
        n_c_c1 = 40'(r_b_c1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_c     <= n_a_c;
        r_a_s     <= n_a_s;
        r_a_carry <= i_carry;

        for (int k = 0; k < 6; k++) begin
            r_b_lo[k] <= $signed(r_a_carry.uu[k]) * $signed({1'b0, n_b_t[16:0]});
            r_b_hi[k] <= $signed(r_a_carry.uu[k]) * $signed(n_b_t[XY_W-1:17]);
        end
        for (int k = 0; k < 3; k++) begin
            r_b_us[k] <= $signed(r_a_carry.u[k]) * r_a_s;
        end
        r_b_c1    <= 34'(rnd68(68'(r_a_c), 1));
        r_b_carry <= r_a_carry;

        r_c_mat.m[0] <= clamp_entry(n_c_c1 + n_c_r[0]);
        r_c_mat.m[4] <= clamp_entry(n_c_c1 + n_c_r[1]);
        r_c_mat.m[8] <= clamp_entry(n_c_c1 + n_c_r[2]);
        r_c_mat.m[1] <= clamp_entry(n_c_r[3] - n_c_s[2]);
        r_c_mat.m[3] <= clamp_entry(n_c_r[3] + n_c_s[2]);
        r_c_mat.m[2] <= clamp_entry(n_c_r[4] + n_c_s[1]);
        r_c_mat.m[6] <= clamp_entry(n_c_r[4] - n_c_s[1]);
        r_c_mat.m[5] <= clamp_entry(n_c_r[5] - n_c_s[0]);
        r_c_mat.m[7] <= clamp_entry(n_c_r[5] + n_c_s[0]);
        r_c_mat.p    <= r_b_carry.p;
        r_c_mat.o    <= r_b_carry.o;
        r_c_mat.deg  <= r_b_carry.deg;
    end

    assign o_valid = r_c_valid;
    assign o_mat   = r_c_mat;

endmodule

/* design/aarp_apply.sv */
`timescale 1ns / 1ps
// ============================================================================
// aarp_apply
// Applies the matrix to the offset from the centre, adds the centre back and
// saturates, with split partial products in the first stage.
// ============================================================================
module aarp_apply (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  aarp_pkg::t_mat i_mat,
    output logic           o_done,
    output logic [31:0]    o_rotated_x,
    output logic [31:0]    o_rotated_y,
    output logic [31:0]    o_rotated_z,
    output logic           o_axis_degenerate,
    output logic           o_clipped
);
    import aarp_pkg::*;

    logic               r_d_valid;
    logic signed [49:0] r_d_lo [9];
    logic signed [47:0] r_d_hi [9];
    logic [2:0][31:0]   r_d_p, r_d_o;
    logic               r_d_deg;
    logic signed [32:0] n_d [3];

    logic               r_e_valid;
    logic [2:0][31:0]   r_e_res;
    logic               r_e_deg, r_e_clip;
    logic signed [39:0] n_e_acc [3];
    logic [2:0][31:0]   n_e_res;
    logic [2:0]         n_e_clip;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_d[j] = 33'($signed(i_mat.p[j])) - 33'($signed(i_mat.o[j]));
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_e_acc[i] = 40'($signed(r_d_o[i]));
            for (int j = 0; j < 3; j++) begin
                n_e_acc[i] = n_e_acc[i] + 40'(rnd68(68'(r_d_hi[3*i+j]) * 68'sd131072
                                                     + 68'(r_d_lo[3*i+j]), 29));
            end
            n_e_clip[i] = 1'b1;
            if (n_e_acc[i] > 40'sd2147483647) begin
                n_e_res[i] = 32'h7FFFFFFF;
            end else if (n_e_acc[i] < -40'sd2147483648) begin
                n_e_res[i] = 32'h80000000;
            end else begin
                n_e_res[i]  = n_e_acc[i][31:0];
                n_e_clip[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            r_d_valid <= i_valid;
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_d_lo[3*i+j] <= $signed(i_mat.m[3*i+j]) * $signed({1'b0, n_d[j][16:0]});
                r_d_hi[3*i+j] <= $signed(i_mat.m[3*i+j]) * $signed(n_d[j][32:17]);
            end
        end
        r_d_p   <= i_mat.p;
        r_d_o   <= i_mat.o;
        r_d_deg <= i_mat.deg;

        r_e_res  <= r_d_deg ? r_d_p : n_e_res;
        r_e_deg  <= r_d_deg;
        r_e_clip <= !r_d_deg && (|n_e_clip);
    end

    assign o_done            = r_e_valid;
    assign o_rotated_x       = r_e_res[0];
    assign o_rotated_y       = r_e_res[1];
    assign o_rotated_z       = r_e_res[2];
    assign o_axis_degenerate = r_e_deg;
    assign o_clipped         = r_e_clip;

endmodule

/* design/axis_angle_rotation_about_point_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// axis_angle_rotation_about_point_core
// Rotates a point about an axis through a centre by a binary angle, using a
// chain of CORDIC cells for cos and sin and a pipelined Rodrigues matrix.
// Throughput: one transaction per cycle; busy is always low.
// Pipeline: the input register, the CORDIC cell chain and five further stages.
// Reset clears all valid flags; results are strobed and never held off.
// ============================================================================
module axis_angle_rotation_about_point_core #(
    parameter int TRIG_STAGES = aarp_pkg::TRIG_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    input  logic [31:0] i_origin_x,
    input  logic [31:0] i_origin_y,
    input  logic [31:0] i_origin_z,
    input  logic [15:0] i_axis_x,
    input  logic [15:0] i_axis_y,
    input  logic [15:0] i_axis_z,
    input  logic [15:0] i_turn_angle,
    output logic        o_done,
    output logic [31:0] o_rotated_x,
    output logic [31:0] o_rotated_y,
    output logic [31:0] o_rotated_z,
    output logic        o_axis_degenerate,
    output logic        o_clipped
);
    import aarp_pkg::*;

    localparam int LATENCY = TRIG_STAGES + 6;

    logic                   r_valid;
    logic signed [XY_W-1:0] r_z0;
    t_carry                 r_carry;
    t_carry                 n_carry;
    logic [47:0]            n_zsum;

    logic                   w_valid [TRIG_STAGES+1];
    logic signed [XY_W-1:0] w_x     [TRIG_STAGES+1];
    logic signed [XY_W-1:0] w_y     [TRIG_STAGES+1];
    logic signed [XY_W-1:0] w_z     [TRIG_STAGES+1];
    t_carry                 w_carry [TRIG_STAGES+1];

    logic                   w_mvalid;
    t_mat                   w_mat;

    assign busy = 1'b0;

    assign n_zsum = 48'(i_turn_angle[13:0]) * 48'(TWO_PI_Q46) + 48'd32768;

    always_comb begin
        n_carry.p    = {i_point_z, i_point_y, i_point_x};
        n_carry.o    = {i_origin_z, i_origin_y, i_origin_x};
        n_carry.u    = {i_axis_z, i_axis_y, i_axis_x};
        n_carry.uu[0] = $signed(i_axis_x) * $signed(i_axis_x);
        n_carry.uu[1] = $signed(i_axis_y) * $signed(i_axis_y);
        n_carry.uu[2] = $signed(i_axis_z) * $signed(i_axis_z);
        n_carry.uu[3] = $signed(i_axis_x) * $signed(i_axis_y);
        n_carry.uu[4] = $signed(i_axis_x) * $signed(i_axis_z);
        n_carry.uu[5] = $signed(i_axis_y) * $signed(i_axis_z);
        n_carry.quad = i_turn_angle[15:14];
        n_carry.deg  = (i_axis_x == 16'd0) && (i_axis_y == 16'd0) && (i_axis_z == 16'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z0    <= $signed({3'b000, n_zsum[46:16]});
        r_carry <= n_carry;
    end

    assign w_valid[0] = r_valid;
    assign w_x[0]     = CORDIC_START;
    assign w_y[0]     = '0;
    assign w_z[0]     = r_z0;
    assign w_carry[0] = r_carry;

    for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
        aarp_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_carry (w_carry[g]),
            .o_valid (w_valid[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_carry (w_carry[g+1])
        );
    end

    aarp_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[TRIG_STAGES]),
        .i_x     (w_x[TRIG_STAGES]),
        .i_y     (w_y[TRIG_STAGES]),
        .i_carry (w_carry[TRIG_STAGES]),
        .o_valid (w_mvalid),
        .o_mat   (w_mat)
    );

    aarp_apply u_apply (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_mvalid),
        .i_mat             (w_mat),
        .o_done            (o_done),
        .o_rotated_x       (o_rotated_x),
        .o_rotated_y       (o_rotated_y),
        .o_rotated_z       (o_rotated_z),
        .o_axis_degenerate (o_axis_degenerate),
        .o_clipped         (o_clipped)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("Accepted transaction did not complete at the expected cycle.");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_axis_degenerate && o_clipped))
        else $error("Degenerate axis result reported as clipped.");

    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((start && !busy) && i_axis_x == 16'd0 && i_axis_y == 16'd0 && i_axis_z == 16'd0)
        |-> ##LATENCY (o_axis_degenerate && o_rotated_x == $past(i_point_x, LATENCY)))
        else $error("Zero axis did not pass the point through.");

endmodule

/* tb/sv/aarp_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// aarp_checker
// Watches the start and done channels of the point rotation core, predicts
// each rotated point from the accepted transaction and compares field by field.
// ============================================================================
module aarp_checker #(
    parameter int TRIG_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    input  logic [31:0] i_origin_x,
    input  logic [31:0] i_origin_y,
    input  logic [31:0] i_origin_z,
    input  logic [15:0] i_axis_x,
    input  logic [15:0] i_axis_y,
    input  logic [15:0] i_axis_z,
    input  logic [15:0] i_turn_angle,
    input  logic        i_done,
    input  logic [31:0] i_rotated_x,
    input  logic [31:0] i_rotated_y,
    input  logic [31:0] i_rotated_z,
    input  logic        i_axis_degenerate,
    input  logic        i_clipped,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        deg;
        logic        clip;
    } t_point;

    t_point rotated_q[$];

    localparam longint ATAN_TABLE [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    function automatic longint round_shift(longint v, int n);
        return ((v >>> (n - 1)) + 1) >>> 1;
    endfunction

    function automatic longint clamp_m(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483647) return -64'sd2147483647;
        return v;
    endfunction

    function automatic t_point rotate_point(
        logic [2:0][31:0] pt, logic [2:0][31:0] org,
        logic [2:0][15:0] ax, logic [15:0] ang);
        t_point r;
        longint p[3], o[3], u[3], d[3], m[3][3];
        longint cx, cy, cz, dx, dy, c, s, t, c1, acc, us;
        r.clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            p[i] = longint'($signed(pt[i]));
            o[i] = longint'($signed(org[i]));
            u[i] = longint'($signed(ax[i]));
        end
        if (u[0] == 0 && u[1] == 0 && u[2] == 0) begin
            r.x = pt[0];
            r.y = pt[1];
            r.z = pt[2];
            r.deg = 1'b1;
            return r;
        end
        r.deg = 1'b0;
        cz = ((longint'(ang[13:0]) * 64'sd6746518852) + 32768) >>> 16;
        cx = 64'sd652032874;
        cy = 0;
        for (int i = 0; i < TRIG_STAGES && i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0) begin
                cx -= dx; cy += dy; cz -= ATAN_TABLE[i];
            end else begin
                cx += dx; cy -= dy; cz += ATAN_TABLE[i];
            end
        end
        case (ang[15:14])
            2'd0: begin c = cx; s = cy; end
            2'd1: begin c = -cy; s = cx; end
            2'd2: begin c = -cx; s = -cy; end
            default: begin c = cy; s = -cx; end
        endcase
        t = 64'sd1073741824 - c;
        c1 = round_shift(c, 1);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = round_shift(u[i] * u[j] * t, 29) + (i == j ? c1 : 0);
        us = round_shift(u[2] * s, 15);
        m[0][1] -= us; m[1][0] += us;
        us = round_shift(u[1] * s, 15);
        m[0][2] += us; m[2][0] -= us;
        us = round_shift(u[0] * s, 15);
        m[1][2] -= us; m[2][1] += us;
        for (int i = 0; i < 3; i++) begin
            d[i] = p[i] - o[i];
            for (int j = 0; j < 3; j++) m[i][j] = clamp_m(m[i][j]);
        end
        for (int i = 0; i < 3; i++) begin
            acc = o[i];
            for (int j = 0; j < 3; j++) acc += round_shift(m[i][j] * d[j], 29);
            if (acc > 64'sd2147483647) begin
                acc = 64'sd2147483647; r.clip = 1'b1;
            end else if (acc < -64'sd2147483648) begin
                acc = -64'sd2147483648; r.clip = 1'b1;
            end
            case (i)
                0: r.x = acc[31:0];
                1: r.y = acc[31:0];
                default: r.z = acc[31:0];
            endcase
        end
        return r;
    endfunction

    assign o_pending = rotated_q.size();

    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else if (i_done) begin
            if (rotated_q.size() == 0) begin
                $error("result with no transaction outstanding");
                o_fail_count <= o_fail_count + 1;
            end else begin
                want = rotated_q.pop_front();
                if (i_rotated_x !== want.x || i_rotated_y !== want.y ||
                    i_rotated_z !== want.z || i_axis_degenerate !== want.deg ||
                    i_clipped !== want.clip) begin
                    if (i_rotated_x !== want.x)
                        $error("rotated_x expected %h actual %h", want.x, i_rotated_x);
                    if (i_rotated_y !== want.y)
                        $error("rotated_y expected %h actual %h", want.y, i_rotated_y);
                    if (i_rotated_z !== want.z)
                        $error("rotated_z expected %h actual %h", want.z, i_rotated_z);
                    if (i_axis_degenerate !== want.deg)
                        $error("axis_degenerate expected %b actual %b", want.deg,
                               i_axis_degenerate);
                    if (i_clipped !== want.clip)
                        $error("clipped expected %b actual %b", want.clip, i_clipped);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
        if (i_rst_n && i_start && !i_busy) begin
            rotated_q.push_back(rotate_point(
                {i_point_z, i_point_y, i_point_x},
                {i_origin_z, i_origin_y, i_origin_x},
                {i_axis_z, i_axis_y, i_axis_x}, i_turn_angle));
        end
    end

endmodule

/* tb/sv/axis_angle_rotation_about_point_core_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// axis_angle_rotation_about_point_core_tb
// Drives directed corner cases and random rotations with random gaps into the
// point rotation core; a checker module predicts and compares every result.
// ============================================================================
module axis_angle_rotation_about_point_core_tb;

    localparam int N_RANDOM  = 830;
    localparam int CYC_LIMIT = 200000;
    localparam logic [15:0] UNIT = 16'sd16384;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_point_x, i_point_y, i_point_z;
    logic [31:0] i_origin_x, i_origin_y, i_origin_z;
    logic [15:0] i_axis_x, i_axis_y, i_axis_z, i_turn_angle;
    logic        o_done;
    logic [31:0] o_rotated_x, o_rotated_y, o_rotated_z;
    logic        o_axis_degenerate, o_clipped;
    int          fail_count;
    int          pending;
    int          cycle_count;

    axis_angle_rotation_about_point_core dut (.*);

    aarp_checker checker_i (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy),
        .i_point_x, .i_point_y, .i_point_z,
        .i_origin_x, .i_origin_y, .i_origin_z,
        .i_axis_x, .i_axis_y, .i_axis_z, .i_turn_angle,
        .i_done(o_done), .i_rotated_x(o_rotated_x), .i_rotated_y(o_rotated_y),
        .i_rotated_z(o_rotated_z), .i_axis_degenerate(o_axis_degenerate),
        .i_clipped(o_clipped), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYC_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return ($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000) ^
                      $urandom_range(0, 255);
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'($urandom());
            2: return ($urandom_range(0, 1) ? UNIT : -UNIT);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic send(input logic [31:0] px, py, pz, ox, oy, oz,
                        input logic [15:0] ax, ay, az, ang);
        int gap;
        i_point_x  <= px; i_point_y  <= py; i_point_z  <= pz;
        i_origin_x <= ox; i_origin_y <= oy; i_origin_z <= oz;
        i_axis_x   <= ax; i_axis_y   <= ay; i_axis_z   <= az;
        i_turn_angle <= ang;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        gap = ($urandom_range(0, 3) == 0) ? 0 :
              ($urandom_range(0, 15) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 2));
        if ($urandom_range(0, 9) < 4) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [31:0] pmax, pmin;
        pmax = 32'h7FFFFFFF;
        pmin = 32'h80000000;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        {i_point_x, i_point_y, i_point_z} <= '0;
        {i_origin_x, i_origin_y, i_origin_z} <= '0;
        {i_axis_x, i_axis_y, i_axis_z, i_turn_angle} <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0, 0, 0, 0, 16'h1234);
        send(pmax, pmin, pmax, pmin, pmax, pmin, 0, 0, 0, 16'hFFFF);
        for (int q = 0; q < 4; q++)
            send(32'h00010000, 0, 0, 0, 0, 0, 0, 0, UNIT, 16'(q * 16384));
        send(32'h00010000, 32'h00010000, 0, 0, 0, 0, UNIT, 0, 0, 16'h3FFF);
        send(0, 32'h00010000, 32'h00010000, 0, 0, 0, 0, UNIT, 0, 16'hC000);
        send(pmax, pmax, pmax, pmin, pmin, pmin, 0, 0, UNIT, 16'h2000);
        send(pmin, pmin, pmin, pmax, pmax, pmax, UNIT, 0, 0, 16'h6000);
        send(pmax, pmin, 0, 0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h4000);
        send(pmin, pmax, pmin, 0, pmax, 0, 16'h8000, 16'h8000, 16'h8000, 16'hA000);
        send(32'h12345678, 32'hDEADBEEF, 32'h0F0F0F0F, 32'h00001000, 0, 0,
             16'h0001, 0, 0, 16'h8000);
        send(32'hFFFFFFFF, 0, 32'h55555555, 0, 32'hAAAAAAAA, 0,
             0, 16'hFFFF, 0, 16'h0001);
        send(32'h00050000, 0, 0, 32'h00050000, 0, 0, 16'd9459, 16'd9459, 16'd9459,
             16'h5555);

        for (int k = 0; k < N_RANDOM; k++)
            send(rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(),
                 rand_axis(), rand_axis(), rand_axis(), 16'($urandom()));
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
